/* design/rks_pkg.sv */
// ----------------------------------------------------------------------------
// rks_pkg
// shared types and constants of the ray k-dop slab test
// ----------------------------------------------------------------------------
package rks_pkg;

  localparam int NUM_SLABS  = 7;
  localparam int COORD_BITS = 32;
  localparam int CW         = COORD_BITS > 32 ? 32 : COORD_BITS;
  localparam int SUM_W      = 34;
  localparam int PROD_W     = 50;
  localparam int PROJ_W     = 35;
  localparam int NUM_W      = 36;
  localparam int DVD_W      = 51;
  localparam int DVS_W      = 35;
  localparam int CNT_W      = 6;
  localparam logic [15:0] DIAG_K = 16'd37837;
  localparam logic [2:0] AXIS_SLABS = 3'd3;
  localparam logic [2:0] DIAG_SLABS = 3'd7;
  localparam logic [2:0] SLAB_LIMIT = 3'(NUM_SLABS < 7 ? NUM_SLABS : 7);
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};

  typedef struct packed {
    logic ld;
    logic sum;
    logic mul;
    logic proj;
    logic par;
    logic div_start;
    logic div_far;
    logic tq_ld_n;
    logic tq_ld_f;
    logic upd;
    logic emit;
  } rks_cmd_t;

  typedef struct packed {
    logic skip;
    logic nd_zero;
    logic div_done;
    logic last;
  } rks_stat_t;

endpackage

/* design/rks_div.sv */
// ----------------------------------------------------------------------------
// rks_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rks_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rks_pkg::DVD_W-1:0] dividend,
  input  logic [rks_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [rks_pkg::DVD_W-1:0] quotient
);
  import rks_pkg::*;

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[DVD_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

/* design/rks_dp.sv */
// ----------------------------------------------------------------------------
// rks_dp
// projection, division, interval narrowing and result register
// ----------------------------------------------------------------------------
module rks_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rks_pkg::rks_cmd_t               cmd,
  output rks_pkg::rks_stat_t              stat,
  input  logic signed [rks_pkg::CW-1:0]   origin_x,
  input  logic signed [rks_pkg::CW-1:0]   origin_y,
  input  logic signed [rks_pkg::CW-1:0]   origin_z,
  input  logic signed [rks_pkg::CW-1:0]   dir_x,
  input  logic signed [rks_pkg::CW-1:0]   dir_y,
  input  logic signed [rks_pkg::CW-1:0]   dir_z,
  input  logic [2:0]                      plane_index,
  input  logic signed [rks_pkg::CW-1:0]   slab_near,
  input  logic signed [rks_pkg::CW-1:0]   slab_far,
  input  logic                            last_slab,
  output logic                            hit,
  output logic signed [rks_pkg::CW-1:0]   t_near,
  output logic signed [rks_pkg::CW-1:0]   t_far
);
  import rks_pkg::*;

  logic signed [CW-1:0]     o_r [3];
  logic signed [CW-1:0]     d_r [3];
  logic [2:0]               idx_r;
  logic signed [CW-1:0]     sn_r, sf_r;
  logic                     last_r;
  logic signed [SUM_W-1:0]  sd_r, so_r, sd_nxt, so_nxt;
  logic [PROD_W-1:0]        pd_r, po_r;
  logic                     negd_r, nego_r;
  logic signed [PROJ_W-1:0] nd_r, nd_nxt, no_nxt;
  logic signed [NUM_W-1:0]  numn_r, numf_r;
  logic signed [CW-1:0]     tn_r, tf_r, lo_r, hi_r, lo_nxt, hi_nxt;
  logic signed [CW-1:0]     tsat, tn_sw, tf_sw;
  logic                     rej_r, rej_nxt, neg_r;
  logic                     hit_r;
  logic signed [CW-1:0]     otn_r, otf_r;
  logic signed [NUM_W-1:0]  num_sel;
  logic [NUM_W-1:0]         num_mag;
  logic [PROJ_W-1:0]        nd_mag;
  logic [DVD_W-1:0]         dvd, quo;
  logic                     div_done;
  logic [SUM_W-1:0]         rd, ro;
  logic signed [SUM_W-1:0]  ax, ay, az, bx, by, bz;

  rks_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (DVS_W'(nd_mag)),
    .done     (div_done),
    .quotient (quo)
  );

  // signed component sums for the diagonal normals
  always_comb begin
    ax = SUM_W'(d_r[0]); ay = SUM_W'(d_r[1]); az = SUM_W'(d_r[2]);
    bx = SUM_W'(o_r[0]); by = SUM_W'(o_r[1]); bz = SUM_W'(o_r[2]);
    unique case (idx_r)
      3'd4:    begin sd_nxt = -ax + ay + az; so_nxt = -bx + by + bz; end
      3'd5:    begin sd_nxt = -ax - ay + az; so_nxt = -bx - by + bz; end
      3'd6:    begin sd_nxt = ax - ay + az;  so_nxt = bx - by + bz;  end
      default: begin sd_nxt = ax + ay + az;  so_nxt = bx + by + bz;  end
    endcase
  end

  // round half away from zero, axes are exact
  always_comb begin
    rd = SUM_W'((pd_r + PROD_W'(32768)) >> 16);
    ro = SUM_W'((po_r + PROD_W'(32768)) >> 16);
    if (idx_r < AXIS_SLABS) begin
      nd_nxt = PROJ_W'(d_r[idx_r[1:0]]);
      no_nxt = PROJ_W'(o_r[idx_r[1:0]]);
    end else begin
      nd_nxt = negd_r ? -$signed({1'b0, rd}) : $signed({1'b0, rd});
      no_nxt = nego_r ? -$signed({1'b0, ro}) : $signed({1'b0, ro});
    end
  end

  always_comb begin
    num_sel = cmd.div_far ? numf_r : numn_r;
    num_mag = num_sel[NUM_W-1] ? NUM_W'(-num_sel) : NUM_W'(num_sel);
    nd_mag  = nd_r[PROJ_W-1] ? PROJ_W'(-nd_r) : PROJ_W'(nd_r);
    dvd     = {num_mag[DVD_W-17:0], 16'd0};
  end

  // saturate the quotient into the signed t range
  always_comb begin
    if (neg_r) begin
      if (quo > DVD_W'(T_MAX) + DVD_W'(1)) tsat = T_MIN;
      else                                 tsat = CW'(-quo);
    end else begin
      if (quo > DVD_W'(T_MAX)) tsat = T_MAX;
      else                     tsat = CW'(quo);
    end
  end

  always_comb begin
    tn_sw   = nd_r[PROJ_W-1] ? tf_r : tn_r;
    tf_sw   = nd_r[PROJ_W-1] ? tn_r : tf_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    rej_nxt = rej_r;
    if (cmd.emit) begin
      lo_nxt  = T_MIN;
      hi_nxt  = T_MAX;
      rej_nxt = 1'b0;
    end else if (cmd.par) begin
      if (numn_r > 0 || numf_r < 0) rej_nxt = 1'b1;
    end else if (cmd.upd) begin
      lo_nxt = (lo_r < tn_sw) ? tn_sw : lo_r;
      hi_nxt = (hi_r > tf_sw) ? tf_sw : hi_r;
      if (lo_nxt > hi_nxt) rej_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r  <= T_MIN;
      hi_r  <= T_MAX;
      rej_r <= 1'b0;
    end else begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      rej_r <= rej_nxt;
    end
    if (cmd.ld) begin
      o_r[0] <= origin_x; o_r[1] <= origin_y; o_r[2] <= origin_z;
      d_r[0] <= dir_x;    d_r[1] <= dir_y;    d_r[2] <= dir_z;
      idx_r  <= plane_index;
      sn_r   <= slab_near;
      sf_r   <= slab_far;
      last_r <= last_slab;
    end
    if (cmd.sum) begin
      sd_r <= sd_nxt;
      so_r <= so_nxt;
    end
    if (cmd.mul) begin
      pd_r   <= PROD_W'(sd_r[SUM_W-1] ? SUM_W'(-sd_r) : SUM_W'(sd_r)) * PROD_W'(DIAG_K);
      po_r   <= PROD_W'(so_r[SUM_W-1] ? SUM_W'(-so_r) : SUM_W'(so_r)) * PROD_W'(DIAG_K);
      negd_r <= sd_r[SUM_W-1];
      nego_r <= so_r[SUM_W-1];
    end
    if (cmd.proj) begin
      nd_r   <= nd_nxt;
      numn_r <= NUM_W'(sn_r) - NUM_W'(no_nxt);
      numf_r <= NUM_W'(sf_r) - NUM_W'(no_nxt);
    end
    if (cmd.div_start) neg_r <= num_sel[NUM_W-1] ^ nd_r[PROJ_W-1];
    if (cmd.tq_ld_n) tn_r <= tsat;
    if (cmd.tq_ld_f) tf_r <= tsat;
    if (cmd.emit) begin
      hit_r <= !rej_r;
      otn_r <= rej_r ? '0 : lo_r;
      otf_r <= rej_r ? '0 : hi_r;
    end
  end

  assign stat.skip     = rej_r || idx_r >= DIAG_SLABS || idx_r >= SLAB_LIMIT;
  assign stat.nd_zero  = nd_r == '0;
  assign stat.div_done = div_done;
  assign stat.last     = last_r;
  assign hit    = hit_r;
  assign t_near = otn_r;
  assign t_far  = otf_r;

endmodule

/* design/rks_ctrl.sv */
// ----------------------------------------------------------------------------
// rks_ctrl
// sequencer for one slab: project, two divisions or a parallel check, narrow, and on the last slab report
// ----------------------------------------------------------------------------
module rks_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output rks_pkg::rks_cmd_t  cmd,
  input  rks_pkg::rks_stat_t stat
);
  import rks_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SUM  = 10'b0000000010,
    S_MUL  = 10'b0000000100,
    S_PROJ = 10'b0000001000,
    S_CHK  = 10'b0000010000,
    S_DIVN = 10'b0000100000,
    S_DIVF = 10'b0001000000,
    S_UPD  = 10'b0010000000,
    S_FIN  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t st_r, st_nxt;
  logic   ov_r, ov_nxt;

  always_comb begin
    st_nxt    = st_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.ld = 1'b1;
          st_nxt = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        st_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        st_nxt  = S_PROJ;
      end
      S_PROJ: begin
        cmd.proj = 1'b1;
        st_nxt   = S_CHK;
      end
      S_CHK: begin
        if (stat.skip) begin
          st_nxt = S_FIN;
        end else if (stat.nd_zero) begin
          cmd.par = 1'b1;
          st_nxt  = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          st_nxt        = S_DIVN;
        end
      end
      S_DIVN: begin
        if (stat.div_done) begin
          cmd.tq_ld_n   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_far   = 1'b1;
          st_nxt        = S_DIVF;
        end
      end
      S_DIVF: begin
        if (stat.div_done) begin
          cmd.tq_ld_f = 1'b1;
          st_nxt      = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        st_nxt  = S_FIN;
      end
      S_FIN: begin
        st_nxt = stat.last ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        // result register must be free before it is reloaded
        if (!ov_r || out_tready) begin
          cmd.emit = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (cmd.emit)      ov_nxt = 1'b1;
    else if (out_tready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_tvalid = ov_r;

endmodule

/* design/ray_kdop_slab_test.sv */
// ----------------------------------------------------------------------------
// ray_kdop_slab_test
// ray against a 7-slab k-dop, one slab per input transfer, q16.16
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | ray, plane index, slab near/far; tlast = last slab
//  out_    | out | t_near, t_far; tuser = hit
//
//  a slab is loaded, summed, scaled, projected and checked, then divided
//  for near and far on the one shared restoring divider, then narrowed
//  and finished; an ignored or parallel slab goes straight to finish
//  the last slab adds a state that loads the result register, which waits
//  there if a previous result is still stalled
//  reset clears the interval and the handshake state
module ray_kdop_slab_test (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, plane_index,
  // slab_near, slab_far, zero fill
  input  logic [263:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // t_near, t_far
  output logic [63:0]  out_tdata,
  // hit
  output logic         out_tuser
);
  import rks_pkg::*;

  rks_cmd_t             cmd;
  rks_stat_t            stat;
  logic signed [CW-1:0] t_near, t_far;

  rks_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  rks_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .origin_x    (in_tdata[31:0]),
    .origin_y    (in_tdata[63:32]),
    .origin_z    (in_tdata[95:64]),
    .dir_x       (in_tdata[127:96]),
    .dir_y       (in_tdata[159:128]),
    .dir_z       (in_tdata[191:160]),
    .plane_index (in_tdata[194:192]),
    .slab_near   (in_tdata[226:195]),
    .slab_far    (in_tdata[258:227]),
    .last_slab   (in_tlast),
    .hit         (out_tuser),
    .t_near      (t_near),
    .t_far       (t_far)
  );

  assign out_tdata = {t_far, t_near};

endmodule
